>>> rtl/ddd_pkg.sv
// Shared constants and types for the doubled delimiter deframer.
package ddd_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam logic [7:0] HEADER_RST = 8'hAA;
  localparam logic [7:0] TAIL_RST   = 8'h55;

  typedef enum logic [0:0] {
    REG_HEADER = 1'b0,
    REG_TAIL   = 1'b1
  } ddd_reg_t;

endpackage

>>> rtl/ddd_store.sv
// Payload store: one write port, one registered read port, copy of entry zero.
module ddd_store #(
  parameter int DEPTH = ddd_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data,
  output logic [7:0]               first_byte
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;
  logic [7:0] first_byte_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && wr_addr == IDX_W'(0)) begin
      first_byte_r <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data    = rd_data_r;
  assign first_byte = first_byte_r;

endmodule

>>> rtl/doubled_delimiter_deframer.sv
// Doubled delimiter deframer top level: frame tracking, payload burst, register port.
// Output: accepting the closing tail loads the burst counter; payload items then leave
//   through the registered store read port and the output register. Input: one byte
//   per cycle while receiving; the payload is read through the single store read port;
//   input stalled during the burst and while an output item is held by out_stall.
// Reset: synchronous, active low; clears count, flags, previous byte and registers
//   to 0xAA/0x55. The payload store is not cleared, no clearing pass.
module doubled_delimiter_deframer #(
  parameter int CAPACITY = ddd_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_byte,
  output logic        out_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [7:0]       header_r, tail_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       prev_byte_r;
  logic             prev_valid_r;
  logic [CNT_W-1:0] emit_rem_r, emit_rem_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             emit_ovf_r, emit_ovf_nxt;
  logic             out_valid_r, out_last_r, out_ovf_r;

  logic             acc, adv, cfg_wr;
  ddd_pkg::ddd_reg_t cfg_reg;
  logic             prev_same, is_tail, is_hdr;
  logic [CNT_W-1:0] cnt_f, cnt_d;
  logic             ovf_f;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [7:0]       rd_data, first_byte;

  assign acc     = in_valid && !in_stall;
  assign in_stall = (emit_rem_r != '0) || (out_valid_r && out_stall);
  assign adv     = (emit_rem_r != '0) && (!out_valid_r || !out_stall);
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = ddd_pkg::ddd_reg_t'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_reg)
      ddd_pkg::REG_HEADER: prdata = {24'b0, header_r};
      ddd_pkg::REG_TAIL:   prdata = {24'b0, tail_r};
      default:             prdata = '0;
    endcase
  end

  assign prev_same = prev_valid_r && (prev_byte_r == in_rx_byte);
  assign is_tail   = (in_rx_byte == tail_r);
  assign is_hdr    = (in_rx_byte == header_r);

  always_comb begin
    cnt_f = cnt_r;
    ovf_f = ovf_r;
    // a held tail is already in the store at cnt_r, unless the store was full
    if (pend_r) begin
      if (cnt_r < CAP_C) begin
        cnt_f = cnt_r + CNT_W'(1);
      end else begin
        ovf_f = 1'b1;
      end
    end
    if (pend_r) begin
      cnt_d = cnt_r;
    end else if (cnt_r != '0) begin
      cnt_d = cnt_r - CNT_W'(1);
    end else begin
      cnt_d = '0;
    end

    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r;
    ovf_nxt      = ovf_r;
    emit_rem_nxt = adv ? emit_rem_r - CNT_W'(1) : emit_rem_r;
    rd_idx_nxt   = adv ? rd_idx_r + IDX_W'(1) : rd_idx_r;
    emit_ovf_nxt = emit_ovf_r;
    wr_en        = 1'b0;
    wr_addr      = cnt_f[IDX_W-1:0];
    wr_data      = in_rx_byte;

    if (acc) begin
      if (is_tail && prev_same) begin
        rd_idx_nxt   = '0;
        emit_ovf_nxt = ovf_r;
        if (ovf_r) begin
          emit_rem_nxt = CNT_W'(1);
        end else if (cnt_d != '0 && first_byte != header_r) begin
          emit_rem_nxt = cnt_d;
        end else begin
          emit_rem_nxt = '0;
        end
        cnt_nxt  = '0;
        pend_nxt = 1'b0;
        ovf_nxt  = 1'b0;
      end else if (is_tail) begin
        cnt_nxt  = cnt_f;
        ovf_nxt  = ovf_f;
        pend_nxt = 1'b1;
        wr_en    = (cnt_f < CAP_C);
        wr_data  = tail_r;
      end else if (is_hdr && prev_same) begin
        cnt_nxt  = '0;
        pend_nxt = 1'b0;
        ovf_nxt  = 1'b0;
      end else begin
        pend_nxt = 1'b0;
        if (cnt_f < CAP_C) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_f + CNT_W'(1);
          ovf_nxt = ovf_f;
        end else begin
          cnt_nxt = cnt_f;
          ovf_nxt = 1'b1;
        end
      end
    end else if (cfg_wr && cfg_reg == ddd_pkg::REG_TAIL && pend_r && cnt_r < CAP_C) begin
      // held tail follows a new tail value
      wr_en   = 1'b1;
      wr_addr = cnt_r[IDX_W-1:0];
      wr_data = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r     <= ddd_pkg::HEADER_RST;
      tail_r       <= ddd_pkg::TAIL_RST;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      ovf_r        <= 1'b0;
      prev_byte_r  <= '0;
      prev_valid_r <= 1'b0;
      emit_rem_r   <= '0;
      rd_idx_r     <= '0;
      emit_ovf_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_reg)
          ddd_pkg::REG_HEADER: header_r <= pwdata[7:0];
          ddd_pkg::REG_TAIL:   tail_r   <= pwdata[7:0];
          default: ;
        endcase
      end
      cnt_r      <= cnt_nxt;
      pend_r     <= pend_nxt;
      ovf_r      <= ovf_nxt;
      emit_rem_r <= emit_rem_nxt;
      rd_idx_r   <= rd_idx_nxt;
      emit_ovf_r <= emit_ovf_nxt;
      if (acc) begin
        prev_byte_r  <= in_rx_byte;
        prev_valid_r <= 1'b1;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_last_r <= (emit_rem_r == CNT_W'(1));
      out_ovf_r  <= emit_ovf_r;
    end
  end

  ddd_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (adv && !emit_ovf_r),
    .rd_addr    (rd_idx_r),
    .rd_data    (rd_data),
    .first_byte (first_byte)
  );

  assign out_valid        = out_valid_r;
  assign out_last_byte    = out_last_r;
  assign out_overflow     = out_ovf_r;
  assign out_payload_byte = out_ovf_r ? 8'h00 : rd_data;

`ifndef SYNTHESIS
  a_stall_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    emit_rem_r != '0 |-> in_stall)
    else $error("item accepted during payload burst");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C)
    else $error("stored count above capacity");

  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_last_byte)
    else $error("overflow result not marked last");

  a_ovf_single: assert property (@(posedge clk) disable iff (!rst_n)
    emit_ovf_r && emit_rem_r != '0 |-> emit_rem_r == CNT_W'(1))
    else $error("overflow burst longer than one item");
`endif

endmodule
